>>> src/sed_pkg.sv
// Shared constants for the string escape decoder: phase codes, error codes
// and the escape characters it recognizes. No dependencies.
package sed_pkg;

   localparam logic [2:0] PHASE_NORMAL = 3'd0;
   localparam logic [2:0] PHASE_ESCAPE = 3'd1;
   localparam logic [2:0] PHASE_HEX    = 3'd2;
   localparam logic [2:0] PHASE_DROP   = 3'd3;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_END_ESC = 3'd1;
   localparam logic [2:0] ERR_END_HEX = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN = 3'd4;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_TAB = 8'h09;

   localparam logic [2:0] DIGITS_X = 3'd2;
   localparam logic [2:0] DIGITS_U = 3'd4;

endpackage

>>> src/string_escape_decoder_utf8_core.sv
// String escape decoder with UTF-8 output: top level.
// Depends on sed_pkg for phase codes, error codes and escape characters.
//
// The block takes one byte of a string literal body per transfer and gives
// its unescaped bytes, one per transfer on the result side. Each input byte
// is decoded in the cycle it is accepted and its results (one to three bytes,
// or none) are loaded into a three-entry result buffer. With bytes that yield
// one result or none, the input runs at one byte per cycle while the result
// side keeps up; a hex escape that yields a two- or three-byte UTF-8 run
// holds the input while the buffer drains. The next byte is accepted in the
// same cycle that the last buffered result is taken. An error gives one
// result with a zero byte and the error code, and the rest of that string is
// dropped.
module string_escape_decoder_utf8_core
   import sed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic [2:0] rsp_error_code
);

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  left_ff, left_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [7:0]  data_ff [3];
   logic [7:0]  data_in [3];
   logic [2:0]  err_ff, err_in;

   logic        req_xfer, rsp_xfer;
   logic [1:0]  n_res;
   logic [7:0]  res_byte [3];
   logic [2:0]  res_err;
   logic [3:0]  hex_val;
   logic        hex_ok;
   logic [15:0] acc_shift;
   logic [2:0]  left_dec;

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_out_byte   = data_ff[0];
   assign rsp_run_last   = (cnt_ff == 2'd1);
   assign rsp_error_code = err_ff;
   assign rsp_xfer       = rsp_valid && rsp_ready;
   assign req_ready      = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_xfer       = req_valid && req_ready;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_in_byte >= 8'h30 && req_in_byte <= 8'h39) begin
         hex_val = req_in_byte[3:0];
      end else if ((req_in_byte >= 8'h61 && req_in_byte <= 8'h66) ||
                   (req_in_byte >= 8'h41 && req_in_byte <= 8'h46)) begin
         hex_val = req_in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_shift = {acc_ff[11:0], hex_val};
   assign left_dec  = left_ff - 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      n_res       = 2'd0;
      res_err     = ERR_OK;
      res_byte[0] = req_in_byte;
      res_byte[1] = 8'h00;
      res_byte[2] = 8'h00;
      unique case (phase_ff)
         PHASE_ESCAPE: begin
            n_res    = 2'd1;
            phase_in = PHASE_NORMAL;
            case (req_in_byte)
               CHAR_N:         res_byte[0] = BYTE_LF;
               CHAR_R:         res_byte[0] = BYTE_CR;
               CHAR_T:         res_byte[0] = BYTE_TAB;
               CHAR_BACKSLASH: res_byte[0] = CHAR_BACKSLASH;
               CHAR_QUOTE:     res_byte[0] = CHAR_QUOTE;
               CHAR_X, CHAR_U: begin
                  res_byte[0] = 8'h00;
                  acc_in      = 16'h0000;
                  if (req_in_last) begin
                     res_err = ERR_END_HEX;
                  end else begin
                     n_res    = 2'd0;
                     phase_in = PHASE_HEX;
                     left_in  = (req_in_byte == CHAR_X) ? DIGITS_X : DIGITS_U;
                  end
               end
               default: begin
                  res_byte[0] = 8'h00;
                  res_err     = ERR_UNKNOWN;
                  phase_in    = PHASE_DROP;
                  left_in     = 3'd0;
                  acc_in      = 16'h0000;
               end
            endcase
         end
         PHASE_HEX: begin
            if (!hex_ok) begin
               n_res       = 2'd1;
               res_byte[0] = 8'h00;
               res_err     = ERR_BAD_HEX;
               phase_in    = PHASE_DROP;
               left_in     = 3'd0;
               acc_in      = 16'h0000;
            end else if (left_dec == 3'd0) begin
               phase_in = PHASE_NORMAL;
               left_in  = 3'd0;
               acc_in   = 16'h0000;
               if (acc_shift < 16'h0080) begin
                  n_res       = 2'd1;
                  res_byte[0] = acc_shift[7:0];
               end else if (acc_shift < 16'h0800) begin
                  n_res       = 2'd2;
                  res_byte[0] = {3'b110, acc_shift[10:6]};
                  res_byte[1] = {2'b10, acc_shift[5:0]};
               end else begin
                  n_res       = 2'd3;
                  res_byte[0] = {4'b1110, acc_shift[15:12]};
                  res_byte[1] = {2'b10, acc_shift[11:6]};
                  res_byte[2] = {2'b10, acc_shift[5:0]};
               end
            end else begin
               left_in = left_dec;
               acc_in  = acc_shift;
               if (req_in_last) begin
                  n_res       = 2'd1;
                  res_byte[0] = 8'h00;
                  res_err     = ERR_END_HEX;
               end
            end
         end
         PHASE_DROP: begin
            n_res = 2'd0;
         end
         default: begin
            if (req_in_byte == CHAR_BACKSLASH) begin
               if (req_in_last) begin
                  n_res       = 2'd1;
                  res_byte[0] = 8'h00;
                  res_err     = ERR_END_ESC;
               end else begin
                  phase_in = PHASE_ESCAPE;
               end
            end else begin
               n_res    = 2'd1;
               phase_in = PHASE_NORMAL;
            end
         end
      endcase
      if (req_in_last) begin
         phase_in = PHASE_NORMAL;
         left_in  = 3'd0;
         acc_in   = 16'h0000;
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      data_in[0] = data_ff[0];
      data_in[1] = data_ff[1];
      data_in[2] = data_ff[2];
      err_in     = err_ff;
      if (rsp_xfer) begin
         cnt_in     = cnt_ff - 2'd1;
         data_in[0] = data_ff[1];
         data_in[1] = data_ff[2];
      end
      if (req_xfer && n_res != 2'd0) begin
         cnt_in     = n_res;
         data_in[0] = res_byte[0];
         data_in[1] = res_byte[1];
         data_in[2] = res_byte[2];
         err_in     = res_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NORMAL;
         left_ff  <= 3'd0;
         acc_ff   <= 16'h0000;
         cnt_ff   <= 2'd0;
         err_ff   <= ERR_OK;
      end else begin
         if (req_xfer) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            acc_ff   <= acc_in;
         end
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= data_in[0];
      data_ff[1] <= data_in[1];
      data_ff[2] <= data_in[2];
   end

endmodule

>>> bench/tb.sv
// Self-checking bench for string_escape_decoder_utf8_core: a clocked driver
// and monitor with a built-in escape decoder that predicts every result byte.
// Depends on sed_pkg and the decoder core only.
module tb;
   import sed_pkg::*;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef struct {
      logic [7:0] data;
      logic       eos;
      bit         drain_first;
   } text_byte_type;

   typedef struct {
      logic [7:0] val;
      logic       run_last;
      logic [2:0] err;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic [2:0] rsp_error_code;

   text_byte_type text_q[$];
   decoded_type   decoded_q[$];
   text_byte_type next_item;
   decoded_type   want;

   logic [2:0]  esc_phase = PHASE_NORMAL;
   logic [2:0]  digits_left = 3'd0;
   logic [15:0] code_point = 16'h0000;

   bit req_taken = 1'b0;
   bit pause_next = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int bytes_in = 0;
   int results_checked = 0;
   int error_reports = 0;
   int strings_queued = 0;
   int mismatches = 0;

   string_escape_decoder_utf8_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_error_code (rsp_error_code)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Returns {is_hex, value} for one byte.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_ZERO + 8'd9) return {1'b1, b[3:0]};
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_A + 8'd5) return {1'b1, 4'(b - CHAR_LOWER_A + 8'd10)};
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_A + 8'd5) return {1'b1, 4'(b - CHAR_UPPER_A + 8'd10)};
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v) - 8'd10;
   endfunction

   function automatic bit skip_cycle();
      if (bytes_in >= 200 && bytes_in < 280) return 1'b0;
      return $urandom_range(0, 99) < 25;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic expect_result(input logic [7:0] v, input logic rl, input logic [2:0] e);
      decoded_type d;
      d.val = v;
      d.run_last = rl;
      d.err = e;
      decoded_q.insert(decoded_q.size(), d);
   endtask

   task automatic expect_error(input logic [2:0] e);
      expect_result(8'h00, 1'b1, e);
      esc_phase = PHASE_DROP;
      digits_left = 3'd0;
      code_point = 16'h0000;
   endtask

   task automatic expect_utf8(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         expect_result(cp[7:0], 1'b1, ERR_OK);
      end else if (cp < 16'h0800) begin
         expect_result({3'b110, cp[10:6]}, 1'b0, ERR_OK);
         expect_result({2'b10, cp[5:0]}, 1'b1, ERR_OK);
      end else begin
         expect_result({4'b1110, cp[15:12]}, 1'b0, ERR_OK);
         expect_result({2'b10, cp[11:6]}, 1'b0, ERR_OK);
         expect_result({2'b10, cp[5:0]}, 1'b1, ERR_OK);
      end
   endtask

   // Decodes one accepted byte and queues the bytes the core must return.
   task automatic decode_byte(input logic [7:0] b, input logic eos);
      logic [4:0] nib;
      logic [7:0] plain;
      bit         simple;
      nib = hex_nibble(b);
      case (esc_phase)
         PHASE_ESCAPE: begin
            simple = 1'b1;
            case (b)
               CHAR_N:         plain = BYTE_LF;
               CHAR_R:         plain = BYTE_CR;
               CHAR_T:         plain = BYTE_TAB;
               CHAR_BACKSLASH: plain = CHAR_BACKSLASH;
               CHAR_QUOTE:     plain = CHAR_QUOTE;
               default:        simple = 1'b0;
            endcase
            if (simple) begin
               expect_result(plain, 1'b1, ERR_OK);
               esc_phase = PHASE_NORMAL;
            end else if (b == CHAR_X || b == CHAR_U) begin
               if (eos) begin
                  expect_error(ERR_END_HEX);
               end else begin
                  esc_phase = PHASE_HEX;
                  digits_left = (b == CHAR_X) ? DIGITS_X : DIGITS_U;
                  code_point = 16'h0000;
               end
            end else begin
               expect_error(ERR_UNKNOWN);
            end
         end
         PHASE_HEX: begin
            if (!nib[4]) begin
               expect_error(ERR_BAD_HEX);
            end else begin
               code_point = {code_point[11:0], nib[3:0]};
               digits_left = digits_left - 3'd1;
               if (digits_left == 3'd0) begin
                  expect_utf8(code_point);
                  esc_phase = PHASE_NORMAL;
                  code_point = 16'h0000;
               end else if (eos) begin
                  expect_error(ERR_END_HEX);
               end
            end
         end
         PHASE_DROP: begin
         end
         default: begin
            if (b == CHAR_BACKSLASH) begin
               if (eos) expect_error(ERR_END_ESC);
               else esc_phase = PHASE_ESCAPE;
            end else begin
               expect_result(b, 1'b1, ERR_OK);
               esc_phase = PHASE_NORMAL;
            end
         end
      endcase
      if (eos) begin
         esc_phase = PHASE_NORMAL;
         digits_left = 3'd0;
         code_point = 16'h0000;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic eos);
      text_byte_type t;
      t.data = b;
      t.eos = eos;
      t.drain_first = pause_next;
      pause_next = 1'b0;
      text_q.insert(text_q.size(), t);
      if (eos) strings_queued++;
   endtask

   task automatic queue_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], ends && (i == s.len() - 1));
   endtask

   task automatic add_hex_escape(ref logic [7:0] s[$], input bit wide, input logic [15:0] cp);
      s.insert(s.size(), CHAR_BACKSLASH);
      s.insert(s.size(), wide ? CHAR_U : CHAR_X);
      if (wide) begin
         s.insert(s.size(), hex_char(cp[15:12]));
         s.insert(s.size(), hex_char(cp[11:8]));
      end
      s.insert(s.size(), hex_char(cp[7:4]));
      s.insert(s.size(), hex_char(cp[3:0]));
   endtask

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      logic [4:0] n;
      do begin
         b = 8'($urandom_range(0, 255));
         n = hex_nibble(b);
      end while (n[4]);
      return b;
   endfunction

   // Builds one string from well-formed tokens, with some broken escapes and
   // an occasional cut that shortens the string and may end it inside an escape.
   task automatic queue_random_string();
      logic [7:0] s[$];
      logic [15:0] cp;
      int tokens;
      int kind;
      int pos;
      tokens = $urandom_range(1, 6);
      for (int k = 0; k < tokens; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            s.insert(s.size(), 8'($urandom_range(0, 255)));
         end else if (kind < 55) begin
            s.insert(s.size(), CHAR_BACKSLASH);
            case ($urandom_range(0, 4))
               0: s.insert(s.size(), CHAR_N);
               1: s.insert(s.size(), CHAR_R);
               2: s.insert(s.size(), CHAR_T);
               3: s.insert(s.size(), CHAR_BACKSLASH);
               default: s.insert(s.size(), CHAR_QUOTE);
            endcase
         end else if (kind < 70) begin
            add_hex_escape(s, 1'b0, 16'($urandom_range(0, 255)));
         end else if (kind < 88) begin
            case ($urandom_range(0, 3))
               0: cp = 16'($urandom_range(0, 16'h007F));
               1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
               2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            endcase
            add_hex_escape(s, 1'b1, cp);
         end else if (kind < 94) begin
            s.insert(s.size(), CHAR_BACKSLASH);
            s.insert(s.size(), 8'($urandom_range(0, 255)));
         end else begin
            pos = s.size();
            add_hex_escape(s, 1'($urandom_range(0, 1)), 16'($urandom()));
            s[pos + 2 + $urandom_range(0, s.size() - pos - 3)] = non_hex_byte();
         end
      end
      if ($urandom_range(0, 99) < 12) begin
         while (s.size() > 1 && $urandom_range(0, 3) != 0) void'(s.pop_back());
      end
      for (int i = 0; i < s.size(); i++) queue_byte(s[i], i == s.size() - 1);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (text_q.size() != 0 && !(text_q[0].drain_first && decoded_q.size() != 0)
             && !skip_cycle()) begin
            next_item = text_q.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= next_item.data;
            req_in_last <= next_item.eos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_in >= 80) begin
         hold_done <= 1'b1;
         hold_left <= 150;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !skip_cycle();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            decode_byte(req_in_byte, req_in_last);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected result byte %02h last %0b error %0d",
                                       rsp_out_byte, rsp_run_last, rsp_error_code));
            end else begin
               want = decoded_q.pop_front();
               results_checked++;
               if (want.err != ERR_OK) error_reports++;
               if (rsp_out_byte !== want.val)
                  flag_mismatch($sformatf("byte %02h, expected %02h", rsp_out_byte, want.val));
               if (rsp_run_last !== want.run_last)
                  flag_mismatch($sformatf("run_last %0b, expected %0b",
                                          rsp_run_last, want.run_last));
               if (rsp_error_code !== want.err)
                  flag_mismatch($sformatf("error %0d, expected %0d", rsp_error_code, want.err));
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d results still expected.", decoded_q.size());
      $display("FAIL string_escape_decoder_utf8_core");
      $finish;
   end

   initial begin
      int first_random;
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_text("\\", 1'b1);
      queue_text("\\x", 1'b1);
      queue_text("\\u07", 1'b1);
      queue_text("\\xgz", 1'b1);
      queue_text("\\u1?", 1'b1);
      queue_text("\\q", 1'b1);
      queue_text("\\Qb", 1'b1);
      queue_text("\\n\\r\\t\\\\\\\"", 1'b1);
      queue_text("\\uFFFF\\xA0\\uD800\\u0000", 1'b1);
      pause_next = 1'b1;
      first_random = text_q.size();
      while (text_q.size() - first_random < 290) begin
         if (text_q.size() - first_random > 250 && text_q.size() - first_random < 260)
            pause_next = 1'b1;
         queue_random_string();
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_valid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d result bytes, %0d of them errors.",
               bytes_in, strings_queued, results_checked, error_reports);
      if (mismatches == 0) begin
         $display("PASS string_escape_decoder_utf8_core");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("FAIL string_escape_decoder_utf8_core");
      end
      $finish;
   end

endmodule
